// ----- rtl/core/midi_channel_message_parser_macros.svh -----
// Assertion macros shared by the checker of the MIDI channel message parser.
// No dependencies; included by files that hold concurrent assertions.
`ifndef MIDI_CHANNEL_MESSAGE_PARSER_MACROS_SVH
`define MIDI_CHANNEL_MESSAGE_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCMP_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCMP_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/mcmp_pkg.sv -----
// Package of the MIDI channel message parser: byte codes, message types and result types.
// No dependencies; imported by every module of the parser.
package mcmp_pkg;

	localparam int BYTE_W = 8;
	localparam int DATA_W = 7;
	localparam int TDATA_W = 24;
	localparam int FLAGS_W = 5;

	// Bit offsets of the result fields in m_tdata.
	localparam int STATUS_LSB = 0;
	localparam int FIRST_LSB = 8;
	localparam int SECOND_LSB = 15;

	// Upper nibble of a status byte.
	localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
	localparam logic [3:0] TYPE_NOTE_ON = 4'h9;
	localparam logic [3:0] TYPE_CONTROL = 4'hB;
	localparam logic [3:0] TYPE_PROGRAM = 4'hC;
	localparam logic [3:0] TYPE_CH_PRESSURE = 4'hD;
	localparam logic [3:0] TYPE_SYSTEM = 4'hF;

	// Controller numbers from this one up are channel mode messages.
	localparam logic [DATA_W-1:0] FIRST_MODE_CTRL = 7'd120;

	// Packed so that note_on lands in the lowest bit.
	typedef struct packed {
		logic program_chg;
		logic mode;
		logic control;
		logic note_off;
		logic note_on;
	} flags_t;

	typedef struct packed {
		logic [BYTE_W-1:0] status;
		logic [DATA_W-1:0] first;
		logic [DATA_W-1:0] second;
		flags_t            flags;
	} result_t;

endpackage

// ----- rtl/core/mcmp_in_reg.sv -----
// Input register stage of the MIDI channel message parser.
// Depends on mcmp_pkg.
module mcmp_in_reg import mcmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // rx_byte[7:0]
	input  logic              take,      // the next stage can consume this cycle
	output logic              valid_s1,
	output logic [BYTE_W-1:0] byte_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

endmodule

// ----- rtl/core/mcmp_parser.sv -----
// Running status state and message decoding of the MIDI channel message parser.
// Depends on mcmp_pkg.
module mcmp_parser import mcmp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,      // byte_s1 is consumed this cycle
	input  logic [BYTE_W-1:0] byte_s1,
	output logic              res_valid,
	output result_t           res
);

	logic [BYTE_W-1:0] status_q;
	logic              pos_q;
	logic              two_q;
	logic [DATA_W-1:0] held_q;

	logic [BYTE_W-1:0] status_d;
	logic              pos_d;
	logic              two_d;
	logic [DATA_W-1:0] held_d;
	logic              emit;
	logic [DATA_W-1:0] first;
	logic [DATA_W-1:0] second;
	logic              rs_ok;
	logic [3:0]        rs_type;
	logic [3:0]        in_type;

	assign rs_type = status_q[7:4];
	assign in_type = byte_s1[7:4];
	assign rs_ok   = status_q[7] && (rs_type != TYPE_SYSTEM);

	always_comb begin
		status_d = status_q;
		pos_d    = pos_q;
		two_d    = two_q;
		held_d   = held_q;
		emit     = 1'b0;
		first    = byte_s1[DATA_W-1:0];
		second   = '0;
		if (!byte_s1[7]) begin
			// Data byte; ignored when there is no channel running status.
			if (rs_ok) begin
				if (pos_q) begin
					pos_d  = 1'b0;
					emit   = 1'b1;
					first  = held_q;
					second = byte_s1[DATA_W-1:0];
				end else if (two_q) begin
					held_d = byte_s1[DATA_W-1:0];
					pos_d  = 1'b1;
				end else begin
					emit = 1'b1;
				end
			end
		end else if (in_type != TYPE_SYSTEM) begin
			status_d = byte_s1;
			pos_d    = 1'b0;
			two_d    = !((in_type == TYPE_PROGRAM) || (in_type == TYPE_CH_PRESSURE));
		end else if (!byte_s1[3]) begin
			// Sysex or system common ends the running status; real time passes by.
			status_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= '0;
			pos_q    <= 1'b0;
			two_q    <= 1'b0;
			held_q   <= '0;
		end else if (fire) begin
			status_q <= status_d;
			pos_q    <= pos_d;
			two_q    <= two_d;
			held_q   <= held_d;
		end
	end

	always_comb begin
		res.status            = status_q;
		res.first             = first;
		res.second            = second;
		res.flags.note_on     = (rs_type == TYPE_NOTE_ON) && (second != '0);
		res.flags.note_off    = (rs_type == TYPE_NOTE_OFF)
			|| ((rs_type == TYPE_NOTE_ON) && (second == '0));
		res.flags.control     = (rs_type == TYPE_CONTROL) && (first < FIRST_MODE_CTRL);
		res.flags.mode        = (rs_type == TYPE_CONTROL) && (first >= FIRST_MODE_CTRL);
		res.flags.program_chg = (rs_type == TYPE_PROGRAM);
	end

	assign res_valid = fire && emit;

endmodule

// ----- rtl/core/mcmp_out_reg.sv -----
// Result register of the MIDI channel message parser, driving the master stream.
// Depends on mcmp_pkg.
module mcmp_out_reg import mcmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  result_t            res,
	output logic               free,      // the register can load this cycle
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // status_byte[7:0], first_data[14:8], second_data[21:15], zero
	output logic [FLAGS_W-1:0] m_tuser    // note_on, note_off, control, mode, program
);

	result_t res_s2;

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && res_valid) begin
			res_s2 <= res;
		end
	end

	assign m_tdata = {2'b00, res_s2.second, res_s2.first, res_s2.status};
	assign m_tuser = res_s2.flags;

endmodule

// ----- rtl/core/midi_channel_message_parser.sv -----
// Top level of the MIDI channel message parser with running status.
// Depends on mcmp_pkg, mcmp_in_reg, mcmp_parser and mcmp_out_reg.
//
//   Channel  Direction  Payload
//   s_*      in         tdata[7:0] = rx_byte
//   m_*      out        tdata = status_byte, first_data, second_data; tuser = five flags
//
// One received byte is accepted every cycle while the output side keeps up.
// A completed message appears on m_tvalid once its last data byte has been accepted into the input
// register and then decoded into the result register.
// When m_tready is low the result register holds and the input register fills, after which
// s_tready drops; nothing is lost or repeated.
// arst_n clears the running status, the data position and both valid flags at once.
module midi_channel_message_parser import mcmp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BYTE_W-1:0]  s_tdata,   // rx_byte[7:0]
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // status_byte[7:0], first_data[14:8], second_data[21:15]
	output logic [FLAGS_W-1:0] m_tuser    // note_on[0], note_off[1], control[2], mode[3], program[4]
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              free;
	logic              res_valid;
	result_t           res;

	// The input register empties whenever the result register can take a result;
	// bytes that give no result pass through the same step so the state stays in order.
	mcmp_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.take     (free),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mcmp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (valid_s1 && free),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	mcmp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.free      (free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- rtl/core/mcmp_checker.sv -----
// Port-level checker of the MIDI channel message parser, bound to the top level.
// Depends on mcmp_pkg and midi_channel_message_parser_macros.svh.
`include "midi_channel_message_parser_macros.svh"

module mcmp_checker import mcmp_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [FLAGS_W-1:0] m_tuser
);

	logic [3:0]        out_type;
	logic [DATA_W-1:0] out_second;
	flags_t            out_flags;

	assign out_type   = m_tdata[STATUS_LSB+7:STATUS_LSB+4];
	assign out_second = m_tdata[SECOND_LSB+DATA_W-1:SECOND_LSB];
	assign out_flags  = m_tuser;

	`MCMP_ASSERT_NOW(a_channel_status, clk, arst_n, m_tvalid, m_tdata[STATUS_LSB+7] && (out_type != TYPE_SYSTEM), "result status is not a channel status")
	`MCMP_ASSERT_NOW(a_flags_exclusive, clk, arst_n, m_tvalid, $onehot0(m_tuser), "more than one message flag set")
	`MCMP_ASSERT_NOW(a_program_one_data, clk, arst_n, m_tvalid && out_flags.program_chg, out_second == '0, "program change carries a second data byte")
	`MCMP_ASSERT_NOW(a_note_on_velocity, clk, arst_n, m_tvalid && out_flags.note_on, (out_type == TYPE_NOTE_ON) && (out_second != '0), "note on flag without nonzero velocity")
	`MCMP_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind midi_channel_message_parser mcmp_checker u_mcmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
